### rtl/rsg_pkg.sv
// shared types, constants and helpers of the rs group classifier
package rsg_pkg;

	localparam int COUNT_WIDTH = 32;
	localparam int PIXELS_PER_GROUP = 4;
	localparam int PIX_W = 24;
	localparam int CH_W = 8;
	localparam int OUT_W = 32;
	localparam int CFG_IDX_W = 2;
	localparam int CFG_DATA_W = 2;
	localparam int VAL_W = 10;
	localparam int SPREAD_W = 12;
	localparam int NUM_MASKS = 2;
	localparam int NUM_COUNTERS = 6;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_SELECT = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_FLIP_ALL_FIRST = 2'd1;

	// channel codes, code three reads as blue
	localparam logic [1:0] CH_RED = 2'd0;
	localparam logic [1:0] CH_GREEN = 2'd1;

	// counter slots
	localparam int CNT_REG = 0;
	localparam int CNT_SING = 1;
	localparam int CNT_UNUS = 2;
	localparam int CNT_NEG_REG = 3;
	localparam int CNT_NEG_SING = 4;
	localparam int CNT_NEG_UNUS = 5;

	// bit i selects pixel i (a, b, c, d)
	localparam logic [PIXELS_PER_GROUP-1:0] GROUP_MASK [NUM_MASKS] = '{4'b1001, 4'b0110};

	typedef logic [CH_W-1:0] chan_t;
	typedef logic signed [VAL_W-1:0] sval_t;

	typedef struct packed {
		logic [1:0] up;
		logic [1:0] down;
		logic [1:0] same;
	} rsg_tally_t;

	function automatic logic [SPREAD_W-1:0] absdiff(sval_t x, sval_t y);
		logic signed [VAL_W:0] d;
		d = {x[VAL_W-1], x} - {y[VAL_W-1], y};
		if (d[VAL_W]) begin
			d = -d;
		end
		return {{(SPREAD_W-VAL_W-1){1'b0}}, d};
	endfunction

	// |a-b| + |d-c| + |b-d| + |c-a|
	function automatic logic [SPREAD_W-1:0] spread(sval_t a, sval_t b, sval_t c, sval_t d);
		return absdiff(a, b) + absdiff(d, c) + absdiff(b, d) + absdiff(c, a);
	endfunction

endpackage

### rtl/rsg_front.sv
// input register: channel pick, optional lsb flip, clear flag
module rsg_front import rsg_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  load,
	input  logic                  drain,
	input  logic [PIX_W-1:0]      pixel_a,
	input  logic [PIX_W-1:0]      pixel_b,
	input  logic [PIX_W-1:0]      pixel_c,
	input  logic [PIX_W-1:0]      pixel_d,
	input  logic                  clear_counts,
	input  logic [1:0]            channel_select,
	input  logic                  flip_all_first,
	output logic                  valid_s1,
	output logic                  clear_s1,
	output chan_t                 val_s1 [PIXELS_PER_GROUP]
);

	logic [PIX_W-1:0] pix [PIXELS_PER_GROUP];
	chan_t            pick [PIXELS_PER_GROUP];

	assign pix[0] = pixel_a;
	assign pix[1] = pixel_b;
	assign pix[2] = pixel_c;
	assign pix[3] = pixel_d;

	always_comb begin
		for (int i = 0; i < PIXELS_PER_GROUP; i++) begin
			unique case (channel_select)
				CH_RED:   pick[i] = pix[i][23:16];
				CH_GREEN: pick[i] = pix[i][15:8];
				default:  pick[i] = pix[i][7:0];
			endcase
			pick[i] = pick[i] ^ {{(CH_W-1){1'b0}}, flip_all_first};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (load) begin
			valid_s1 <= 1'b1;
		end else if (drain) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			clear_s1 <= clear_counts;
			for (int i = 0; i < PIXELS_PER_GROUP; i++) begin
				val_s1[i] <= pick[i];
			end
		end
	end

endmodule

### rtl/rsg_classify.sv
// variation sums and regular / singular / unusable tallies for both masks
module rsg_classify import rsg_pkg::*; (
	input  chan_t      val [PIXELS_PER_GROUP],
	output rsg_tally_t pos_tally,
	output rsg_tally_t neg_tally
);

	sval_t                base_v [PIXELS_PER_GROUP];
	sval_t                pos_v  [NUM_MASKS][PIXELS_PER_GROUP];
	sval_t                neg_v  [NUM_MASKS][PIXELS_PER_GROUP];
	logic [SPREAD_W-1:0]  base_sum;
	logic [SPREAD_W-1:0]  pos_sum [NUM_MASKS];
	logic [SPREAD_W-1:0]  neg_sum [NUM_MASKS];

	always_comb begin
		for (int i = 0; i < PIXELS_PER_GROUP; i++) begin
			base_v[i] = sval_t'({2'b00, val[i]});
		end
		for (int m = 0; m < NUM_MASKS; m++) begin
			for (int i = 0; i < PIXELS_PER_GROUP; i++) begin
				if (GROUP_MASK[m][i]) begin
					// f1 swaps 2n and 2n+1, f-1 swaps 2n-1 and 2n
					pos_v[m][i] = base_v[i] ^ sval_t'(1);
					neg_v[m][i] = val[i][0] ? base_v[i] + sval_t'(1)
					                        : base_v[i] - sval_t'(1);
				end else begin
					pos_v[m][i] = base_v[i];
					neg_v[m][i] = base_v[i];
				end
			end
		end
	end

	always_comb begin
		base_sum = spread(base_v[0], base_v[1], base_v[2], base_v[3]);
		pos_tally = '0;
		neg_tally = '0;
		for (int m = 0; m < NUM_MASKS; m++) begin
			pos_sum[m] = spread(pos_v[m][0], pos_v[m][1], pos_v[m][2], pos_v[m][3]);
			neg_sum[m] = spread(neg_v[m][0], neg_v[m][1], neg_v[m][2], neg_v[m][3]);
			if (pos_sum[m] > base_sum) begin
				pos_tally.up = pos_tally.up + 2'd1;
			end else if (pos_sum[m] < base_sum) begin
				pos_tally.down = pos_tally.down + 2'd1;
			end else begin
				pos_tally.same = pos_tally.same + 2'd1;
			end
			if (neg_sum[m] > base_sum) begin
				neg_tally.up = neg_tally.up + 2'd1;
			end else if (neg_sum[m] < base_sum) begin
				neg_tally.down = neg_tally.down + 2'd1;
			end else begin
				neg_tally.same = neg_tally.same + 2'd1;
			end
		end
	end

endmodule

### rtl/rs_steganalysis_group_classifier_unit.sv
// top level of the rs steganalysis group classifier: handshake, config, counters
//
// One 2x2 group (pixels a b / c d) is taken per transfer on the input channel and
// one result transfer follows per group, carrying the six running counters after
// that group has been counted. Every group adds exactly two to each family
// (positive flip: regular + singular + unusable, negative flip: the same), one per
// mask. The block takes one group per cycle while the result is not stalled: a
// group first sits in the input register, where the channel is picked and the lsb
// flip applied, then the variation sums and compares run in one combinational pass
// and land straight in the counters, which double as the output register. Result
// valid rises once the group has been written into the counters, after the input
// register. The input stalls only while both the input register and the counter stage
// hold a group and the result is stalled. Counters saturate at all ones and
// clear_counts zeroes them before its own group is counted. Configuration writes
// take effect at the next group taken in and should only be made with the block idle.
module rs_steganalysis_group_classifier_unit import rsg_pkg::*; (
	input  logic                  clk,
	input  logic                  arst_n,
	// configuration write port
	input  logic                  cfg_wr_en,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data,
	// group input
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [PIX_W-1:0]      pixel_a,
	input  logic [PIX_W-1:0]      pixel_b,
	input  logic [PIX_W-1:0]      pixel_c,
	input  logic [PIX_W-1:0]      pixel_d,
	input  logic                  clear_counts,
	// counter output
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [OUT_W-1:0]      regular_count,
	output logic [OUT_W-1:0]      singular_count,
	output logic [OUT_W-1:0]      unusable_count,
	output logic [OUT_W-1:0]      neg_regular_count,
	output logic [OUT_W-1:0]      neg_singular_count,
	output logic [OUT_W-1:0]      neg_unusable_count
);

	logic [1:0]              channel_select_q;
	logic                    flip_all_first_q;
	logic                    advance;
	logic                    in_xfer;
	logic                    valid_s1;
	logic                    clear_s1;
	chan_t                   val_s1 [PIXELS_PER_GROUP];
	rsg_tally_t              pos_tally;
	rsg_tally_t              neg_tally;
	logic [1:0]              incr [NUM_COUNTERS];
	logic [COUNT_WIDTH-1:0]  cnt_q [NUM_COUNTERS];
	logic [COUNT_WIDTH-1:0]  cnt_next [NUM_COUNTERS];
	logic                    out_valid_q;

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			channel_select_q <= '0;
			flip_all_first_q <= 1'b0;
		end else if (cfg_wr_en) begin
			unique case (cfg_index)
				REG_CHANNEL_SELECT: channel_select_q <= cfg_data[1:0];
				REG_FLIP_ALL_FIRST: flip_all_first_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// the counter stage moves when it is empty or its result is being taken
	assign advance  = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !advance;
	assign in_xfer  = in_valid && !in_stall;

	rsg_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.load           (in_xfer),
		.drain          (advance),
		.pixel_a        (pixel_a),
		.pixel_b        (pixel_b),
		.pixel_c        (pixel_c),
		.pixel_d        (pixel_d),
		.clear_counts   (clear_counts),
		.channel_select (channel_select_q),
		.flip_all_first (flip_all_first_q),
		.valid_s1       (valid_s1),
		.clear_s1       (clear_s1),
		.val_s1         (val_s1)
	);

	rsg_classify u_classify (
		.val       (val_s1),
		.pos_tally (pos_tally),
		.neg_tally (neg_tally)
	);

	assign incr[CNT_REG]      = pos_tally.up;
	assign incr[CNT_SING]     = pos_tally.down;
	assign incr[CNT_UNUS]     = pos_tally.same;
	assign incr[CNT_NEG_REG]  = neg_tally.up;
	assign incr[CNT_NEG_SING] = neg_tally.down;
	assign incr[CNT_NEG_UNUS] = neg_tally.same;

	// saturating add of 0..2, starting from zero on a clearing group
	always_comb begin
		logic [COUNT_WIDTH:0] sum;
		for (int k = 0; k < NUM_COUNTERS; k++) begin
			sum = (clear_s1 ? '0 : {1'b0, cnt_q[k]}) + (COUNT_WIDTH+1)'(incr[k]);
			cnt_next[k] = sum[COUNT_WIDTH] ? '1 : sum[COUNT_WIDTH-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			for (int k = 0; k < NUM_COUNTERS; k++) begin
				cnt_q[k] <= '0;
			end
		end else if (advance) begin
			out_valid_q <= valid_s1;
			if (valid_s1) begin
				for (int k = 0; k < NUM_COUNTERS; k++) begin
					cnt_q[k] <= cnt_next[k];
				end
			end
		end
	end

	assign out_valid          = out_valid_q;
	assign regular_count      = OUT_W'(cnt_q[CNT_REG]);
	assign singular_count     = OUT_W'(cnt_q[CNT_SING]);
	assign unusable_count     = OUT_W'(cnt_q[CNT_UNUS]);
	assign neg_regular_count  = OUT_W'(cnt_q[CNT_NEG_REG]);
	assign neg_singular_count = OUT_W'(cnt_q[CNT_NEG_SING]);
	assign neg_unusable_count = OUT_W'(cnt_q[CNT_NEG_UNUS]);

	// each mask lands in exactly one bin per family
	a_pos_two: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> (3'(pos_tally.up) + 3'(pos_tally.down) + 3'(pos_tally.same) == 3'd2))
		else $error("positive tally does not sum to two");

	a_neg_two: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |-> (3'(neg_tally.up) + 3'(neg_tally.down) + 3'(neg_tally.same) == 3'd2))
		else $error("negative tally does not sum to two");

	// counters only move when a group enters the counter stage
	a_cnt_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!(valid_s1 && advance) |=> $stable(cnt_q[CNT_REG]) && $stable(cnt_q[CNT_NEG_UNUS]))
		else $error("counter changed without a group");

	// a clearing group leaves small counts behind
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && advance && clear_s1) |=>
			(cnt_q[CNT_REG] <= COUNT_WIDTH'(2)) && (cnt_q[CNT_NEG_SING] <= COUNT_WIDTH'(2)))
		else $error("clear did not reset counters");

	// the input side only stalls behind a held group
	a_stall: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid_q && out_stall))
		else $error("input stalled without backpressure");

endmodule
